FILE: design/glr_pkg.sv
// Shared types and constants for the gradient line rasterizer.
package glr_pkg;

  // Interpolated quantities: the minor coordinate, then red, green, blue, alpha.
  localparam int NUM_LANES  = 5;
  localparam int LANE_W     = 3;
  localparam int LANE_MINOR = 0;
  localparam int LANE_LAST  = NUM_LANES - 1;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/glr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module glr_divider #(
  parameter int DVD_W = 8,
  parameter int DVS_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output logic [DVS_W-1:0]     remainder,
  output glr_pkg::div_stat_t   stat
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_nxt = fits ? (trial - {1'b0, div_r}) : trial;
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r[DVS_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: design/gradient_line_rasterizer_core.sv
// Gradient line rasterizer top level: segment in, one colored pixel per transaction out.
//
// Each input transaction is a segment with two endpoints and an RGBA color at
// each end. The core emits every pixel along the major axis (x when |dx| > |dy|,
// otherwise y) in ascending major order, with the minor coordinate and each
// channel interpolated exactly and floored; last_pixel marks the final one.
// The core takes one segment at a time and in_ready is low until its last
// pixel is taken. The segment is captured, then five divisions (minor slope
// and four color slopes) run in turn on one shared serial divider, then
// pixels leave at one pixel per cycle while out_ready is high. A zero-length
// segment skips the divisions and gives its single pixel right after
// capture. Pixels leave from the accumulator registers, so out_ready low
// simply holds the current pixel.
module gradient_line_rasterizer_core #(
  parameter int COORD_BITS   = 6,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_x_a,
  input  logic [COORD_BITS-1:0]   in_y_a,
  input  logic [COORD_BITS-1:0]   in_x_b,
  input  logic [COORD_BITS-1:0]   in_y_b,
  input  logic [CHANNEL_BITS-1:0] in_red_a,
  input  logic [CHANNEL_BITS-1:0] in_green_a,
  input  logic [CHANNEL_BITS-1:0] in_blue_a,
  input  logic [CHANNEL_BITS-1:0] in_alpha_a,
  input  logic [CHANNEL_BITS-1:0] in_red_b,
  input  logic [CHANNEL_BITS-1:0] in_green_b,
  input  logic [CHANNEL_BITS-1:0] in_blue_b,
  input  logic [CHANNEL_BITS-1:0] in_alpha_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_pixel_x,
  output logic [COORD_BITS-1:0]   out_pixel_y,
  output logic [CHANNEL_BITS-1:0] out_pixel_red,
  output logic [CHANNEL_BITS-1:0] out_pixel_green,
  output logic [CHANNEL_BITS-1:0] out_pixel_blue,
  output logic [CHANNEL_BITS-1:0] out_pixel_alpha,
  output logic                    out_last_pixel
);

  localparam int C     = COORD_BITS;
  localparam int W     = (CHANNEL_BITS > COORD_BITS) ? CHANNEL_BITS : COORD_BITS;
  localparam int LANES = glr_pkg::NUM_LANES;
  localparam int LW    = glr_pkg::LANE_W;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_DIV_START = 2'd1;
  localparam logic [1:0] ST_DIV_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT      = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] lane_r, lane_nxt;
  logic [C-1:0]  len_r, len_nxt;     // major-axis length N
  logic [C-1:0]  cnt_r, cnt_nxt;     // pixels already taken
  logic [C-1:0]  maj_r, maj_nxt;     // current major coordinate
  logic          xmaj_r, xmaj_nxt;

  // Per lane: running value, value at the far end, floored step and its remainder,
  // and the fractional accumulator.
  logic [W-1:0]  val_r  [LANES];
  logic [W-1:0]  val_nxt[LANES];
  logic [W-1:0]  tgt_r  [LANES];
  logic [W-1:0]  tgt_nxt[LANES];
  logic [W-1:0]  step_q_r  [LANES];
  logic [W-1:0]  step_q_nxt[LANES];
  logic [C-1:0]  step_r_r  [LANES];
  logic [C-1:0]  step_r_nxt[LANES];
  logic [C-1:0]  acc_r  [LANES];
  logic [C-1:0]  acc_nxt[LANES];

  // Segment setup.
  logic          in_fire;
  logic [C-1:0]  adx, ady;
  logic          x_major;
  logic [C-1:0]  maj_a, maj_b, min_a, min_b;
  logic          rev;
  logic [C-1:0]  seg_len;
  logic [W-1:0]  start_v[LANES];
  logic [W-1:0]  end_v  [LANES];

  assign in_fire = in_valid && in_ready;
  assign adx     = (in_x_b >= in_x_a) ? (in_x_b - in_x_a) : (in_x_a - in_x_b);
  assign ady     = (in_y_b >= in_y_a) ? (in_y_b - in_y_a) : (in_y_a - in_y_b);
  assign x_major = (adx > ady);
  assign maj_a   = x_major ? in_x_a : in_y_a;
  assign maj_b   = x_major ? in_x_b : in_y_b;
  assign min_a   = x_major ? in_y_a : in_x_a;
  assign min_b   = x_major ? in_y_b : in_x_b;
  // Walk from the endpoint with the smaller major coordinate; keep a on a tie.
  assign rev     = (maj_b < maj_a);
  assign seg_len = rev ? (maj_a - maj_b) : (maj_b - maj_a);

  always_comb begin
    start_v[glr_pkg::LANE_MINOR] = W'(rev ? min_b : min_a);
    end_v[glr_pkg::LANE_MINOR]   = W'(rev ? min_a : min_b);
    start_v[1] = W'(rev ? in_red_b   : in_red_a);
    end_v[1]   = W'(rev ? in_red_a   : in_red_b);
    start_v[2] = W'(rev ? in_green_b : in_green_a);
    end_v[2]   = W'(rev ? in_green_a : in_green_b);
    start_v[3] = W'(rev ? in_blue_b  : in_blue_a);
    end_v[3]   = W'(rev ? in_blue_a  : in_blue_b);
    start_v[4] = W'(rev ? in_alpha_b : in_alpha_a);
    end_v[4]   = W'(rev ? in_alpha_a : in_alpha_b);
  end

  // Slope of the selected lane: signed difference over N, floored.
  logic [W:0]          diff;
  logic                diff_neg;
  logic [W-1:0]        diff_abs;
  logic [W-1:0]        div_q;
  logic [C-1:0]        div_rem;
  logic                rem_zero;
  glr_pkg::div_stat_t  div_stat;

  assign diff     = {1'b0, tgt_r[lane_r]} - {1'b0, val_r[lane_r]};
  assign diff_neg = diff[W];
  assign diff_abs = diff_neg ? W'(-diff) : diff[W-1:0];
  assign rem_zero = (div_rem == '0);

  glr_divider #(
    .DVD_W(W),
    .DVS_W(C)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIV_START),
    .dividend (diff_abs),
    .divisor  (len_r),
    .quotient (div_q),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  logic last_pix;
  assign last_pix = (cnt_r == len_r);

  always_comb begin
    logic [C:0] sum;
    state_nxt = state_r;
    lane_nxt  = lane_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    maj_nxt   = maj_r;
    xmaj_nxt  = xmaj_r;
    sum       = '0;
    for (int i = 0; i < LANES; i++) begin
      val_nxt[i]    = val_r[i];
      tgt_nxt[i]    = tgt_r[i];
      step_q_nxt[i] = step_q_r[i];
      step_r_nxt[i] = step_r_r[i];
      acc_nxt[i]    = acc_r[i];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          for (int i = 0; i < LANES; i++) begin
            val_nxt[i] = start_v[i];
            tgt_nxt[i] = end_v[i];
            acc_nxt[i] = '0;
          end
          len_nxt   = seg_len;
          cnt_nxt   = '0;
          maj_nxt   = rev ? maj_b : maj_a;
          xmaj_nxt  = x_major;
          lane_nxt  = '0;
          // a point needs no slopes
          state_nxt = (seg_len == '0) ? ST_EMIT : ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          // floor of a negative quotient: -q, or -q-1 with remainder N-r
          if (!diff_neg) begin
            step_q_nxt[lane_r] = div_q;
            step_r_nxt[lane_r] = div_rem;
          end else if (rem_zero) begin
            step_q_nxt[lane_r] = -div_q;
            step_r_nxt[lane_r] = '0;
          end else begin
            step_q_nxt[lane_r] = ~div_q;
            step_r_nxt[lane_r] = len_r - div_rem;
          end
          if (lane_r == LW'(glr_pkg::LANE_LAST)) begin
            state_nxt = ST_EMIT;
          end else begin
            lane_nxt  = lane_r + 1'b1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (last_pix) begin
            state_nxt = ST_IDLE;
          end else begin
            // advance every lane by its step, carrying the fraction
            for (int i = 0; i < LANES; i++) begin
              sum = {1'b0, acc_r[i]} + {1'b0, step_r_r[i]};
              if (sum >= {1'b0, len_r}) begin
                acc_nxt[i] = C'(sum - {1'b0, len_r});
                val_nxt[i] = val_r[i] + step_q_r[i] + W'(1);
              end else begin
                acc_nxt[i] = sum[C-1:0];
                val_nxt[i] = val_r[i] + step_q_r[i];
              end
            end
            cnt_nxt = cnt_r + 1'b1;
            maj_nxt = maj_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    maj_r  <= maj_nxt;
    xmaj_r <= xmaj_nxt;
    for (int i = 0; i < LANES; i++) begin
      val_r[i]    <= val_nxt[i];
      tgt_r[i]    <= tgt_nxt[i];
      step_q_r[i] <= step_q_nxt[i];
      step_r_r[i] <= step_r_nxt[i];
      acc_r[i]    <= acc_nxt[i];
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_pixel_x     = xmaj_r ? maj_r : val_r[glr_pkg::LANE_MINOR][C-1:0];
  assign out_pixel_y     = xmaj_r ? val_r[glr_pkg::LANE_MINOR][C-1:0] : maj_r;
  assign out_pixel_red   = val_r[1][CHANNEL_BITS-1:0];
  assign out_pixel_green = val_r[2][CHANNEL_BITS-1:0];
  assign out_pixel_blue  = val_r[3][CHANNEL_BITS-1:0];
  assign out_pixel_alpha = val_r[4][CHANNEL_BITS-1:0];
  assign out_last_pixel  = last_pix;

endmodule

FILE: sim/gradient_line_rasterizer_core_tb.sv
// Self-checking testbench for the gradient line rasterizer core.
module gradient_line_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = 6;
  localparam int CHAN_W     = 8;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int CHAN_MAX   = (1 << CHAN_W) - 1;
  // Divider work plus a full 64-pixel run, with margin.
  localparam int TAIL_CYCLES = 160;
  // Long receiver hold-off, well past one segment's setup time.
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_CAP  = 100;

  // Channel order inside the color arrays used by the predictor.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef struct packed {
    logic [COORD_W-1:0] x_a;
    logic [COORD_W-1:0] y_a;
    logic [COORD_W-1:0] x_b;
    logic [COORD_W-1:0] y_b;
    logic [CHAN_W-1:0]  red_a;
    logic [CHAN_W-1:0]  green_a;
    logic [CHAN_W-1:0]  blue_a;
    logic [CHAN_W-1:0]  alpha_a;
    logic [CHAN_W-1:0]  red_b;
    logic [CHAN_W-1:0]  green_b;
    logic [CHAN_W-1:0]  blue_b;
    logic [CHAN_W-1:0]  alpha_b;
  } segment_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic               last;
  } pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] in_x_a     = '0;
  logic [COORD_W-1:0] in_y_a     = '0;
  logic [COORD_W-1:0] in_x_b     = '0;
  logic [COORD_W-1:0] in_y_b     = '0;
  logic [CHAN_W-1:0]  in_red_a   = '0;
  logic [CHAN_W-1:0]  in_green_a = '0;
  logic [CHAN_W-1:0]  in_blue_a  = '0;
  logic [CHAN_W-1:0]  in_alpha_a = '0;
  logic [CHAN_W-1:0]  in_red_b   = '0;
  logic [CHAN_W-1:0]  in_green_b = '0;
  logic [CHAN_W-1:0]  in_blue_b  = '0;
  logic [CHAN_W-1:0]  in_alpha_b = '0;

  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [COORD_W-1:0] out_pixel_x;
  logic [COORD_W-1:0] out_pixel_y;
  logic [CHAN_W-1:0]  out_pixel_red;
  logic [CHAN_W-1:0]  out_pixel_green;
  logic [CHAN_W-1:0]  out_pixel_blue;
  logic [CHAN_W-1:0]  out_pixel_alpha;
  logic               out_last_pixel;

  // Pixels predicted for accepted segments, oldest first.
  pixel_t pixels_due[$];
  int     mismatches = 0;

  // Random idling on both channels; cleared for the final stretch of the run.
  bit idle_on    = 1'b0;
  // Set by a test to start one long receiver hold-off.
  bit hold_start = 1'b0;
  int hold_left  = 0;
  int stall_left = 0;

  gradient_line_rasterizer_core #(
    .COORD_BITS  (COORD_W),
    .CHANNEL_BITS(CHAN_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_a         (in_x_a),
    .in_y_a         (in_y_a),
    .in_x_b         (in_x_b),
    .in_y_b         (in_y_b),
    .in_red_a       (in_red_a),
    .in_green_a     (in_green_a),
    .in_blue_a      (in_blue_a),
    .in_alpha_a     (in_alpha_a),
    .in_red_b       (in_red_b),
    .in_green_b     (in_green_b),
    .in_blue_b      (in_blue_b),
    .in_alpha_b     (in_alpha_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_red  (out_pixel_red),
    .out_pixel_green(out_pixel_green),
    .out_pixel_blue (out_pixel_blue),
    .out_pixel_alpha(out_pixel_alpha),
    .out_last_pixel (out_last_pixel)
  );

  always #10 clk = ~clk;

  // Hard stop in case the core hangs; several times the slowest legal run.
  initial begin
    #15000000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Integer quotient rounded toward minus infinity.
  function automatic int floor_quot(int n, int d);
    int q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // Walk the major axis from the low end to the high end and queue one pixel
  // per major coordinate. Minor coordinate and channels are interpolated from
  // endpoint a as exact rationals and floored.
  task automatic predict_pixels(input segment_t s);
    int     col_a[4];
    int     col_b[4];
    int     dx;
    int     dy;
    int     maj_a;
    int     min_a;
    int     dmaj;
    int     dmin;
    int     lo;
    int     hi;
    int     k;
    int     mn;
    int     m;
    int     c;
    int     val[4];
    bit     x_major;
    pixel_t p;
    col_a[CH_RED]   = int'(s.red_a);
    col_a[CH_GREEN] = int'(s.green_a);
    col_a[CH_BLUE]  = int'(s.blue_a);
    col_a[CH_ALPHA] = int'(s.alpha_a);
    col_b[CH_RED]   = int'(s.red_b);
    col_b[CH_GREEN] = int'(s.green_b);
    col_b[CH_BLUE]  = int'(s.blue_b);
    col_b[CH_ALPHA] = int'(s.alpha_b);
    dx = int'(s.x_b) - int'(s.x_a);
    dy = int'(s.y_b) - int'(s.y_a);

    // Zero-length segment: one pixel at endpoint a in color a.
    if (dx == 0 && dy == 0) begin
      p = '{x: s.x_a, y: s.y_a, red: s.red_a, green: s.green_a,
            blue: s.blue_a, alpha: s.alpha_a, last: 1'b1};
      pixels_due.push_back(p);
      return;
    end

    // Ties between |dx| and |dy| go to the y axis.
    x_major = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
    if (x_major) begin
      maj_a = int'(s.x_a); min_a = int'(s.y_a); dmaj = dx; dmin = dy;
    end else begin
      maj_a = int'(s.y_a); min_a = int'(s.x_a); dmaj = dy; dmin = dx;
    end
    lo = (dmaj > 0) ? maj_a : maj_a + dmaj;
    hi = (dmaj > 0) ? maj_a + dmaj : maj_a;

    for (m = lo; m <= hi; m++) begin
      k  = m - maj_a;
      mn = min_a + floor_quot(k * dmin, dmaj);
      for (c = 0; c < 4; c++) val[c] = col_a[c] + floor_quot(k * (col_b[c] - col_a[c]), dmaj);
      p.x     = x_major ? COORD_W'(m) : COORD_W'(mn);
      p.y     = x_major ? COORD_W'(mn) : COORD_W'(m);
      p.red   = CHAN_W'(val[CH_RED]);
      p.green = CHAN_W'(val[CH_GREEN]);
      p.blue  = CHAN_W'(val[CH_BLUE]);
      p.alpha = CHAN_W'(val[CH_ALPHA]);
      p.last  = (m == hi);
      pixels_due.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each pixel transaction, then decide the next ready
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare the pixel on the output ports against the oldest prediction.
  task automatic check_pixel();
    pixel_t want;
    if (pixels_due.size() == 0) begin
      report_mismatch("pixel with no segment outstanding", 1, 0);
      return;
    end
    want = pixels_due.pop_front();
    if (out_pixel_x !== want.x)
      report_mismatch("pixel_x", int'(out_pixel_x), int'(want.x));
    if (out_pixel_y !== want.y)
      report_mismatch("pixel_y", int'(out_pixel_y), int'(want.y));
    if (out_pixel_red !== want.red)
      report_mismatch("pixel_red", int'(out_pixel_red), int'(want.red));
    if (out_pixel_green !== want.green)
      report_mismatch("pixel_green", int'(out_pixel_green), int'(want.green));
    if (out_pixel_blue !== want.blue)
      report_mismatch("pixel_blue", int'(out_pixel_blue), int'(want.blue));
    if (out_pixel_alpha !== want.alpha)
      report_mismatch("pixel_alpha", int'(out_pixel_alpha), int'(want.alpha));
    if (out_last_pixel !== want.last)
      report_mismatch("last_pixel", int'(out_last_pixel), int'(want.last));
  endtask

  // Values read here are the ones settled before this edge, so a pixel counts
  // as taken exactly when valid and ready were both high going into the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) check_pixel();

    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      // Hold off for a long stretch so the core backs up into its input.
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      // Start a stall burst, this one included; stall_left holds its random remainder.
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one segment and hold it until the core takes it. Valid is left high
  // on return; the next call either reuses it or drops it for an idle burst.
  task automatic offer_segment(input segment_t s);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_a     <= s.x_a;
    in_y_a     <= s.y_a;
    in_x_b     <= s.x_b;
    in_y_b     <= s.y_b;
    in_red_a   <= s.red_a;
    in_green_a <= s.green_a;
    in_blue_a  <= s.blue_a;
    in_alpha_a <= s.alpha_a;
    in_red_b   <= s.red_b;
    in_green_b <= s.green_b;
    in_blue_b  <= s.blue_b;
    in_alpha_b <= s.alpha_b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_pixels(s);
  endtask

  // Drop valid and wait for every predicted pixel, then let the core settle.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Colors packed as 0xRRGGBBAA.
  function automatic segment_t make_segment(int xa, int ya, int xb, int yb,
                                            logic [31:0] rgba_a, logic [31:0] rgba_b);
    segment_t s;
    s.x_a     = COORD_W'(xa);
    s.y_a     = COORD_W'(ya);
    s.x_b     = COORD_W'(xb);
    s.y_b     = COORD_W'(yb);
    s.red_a   = rgba_a[31:24];
    s.green_a = rgba_a[23:16];
    s.blue_a  = rgba_a[15:8];
    s.alpha_a = rgba_a[7:0];
    s.red_b   = rgba_b[31:24];
    s.green_b = rgba_b[23:16];
    s.blue_b  = rgba_b[15:8];
    s.alpha_b = rgba_b[7:0];
    return s;
  endfunction

  // Channel value biased toward the extremes.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CHAN_W'(CHAN_MAX);
      default: return CHAN_W'($urandom_range(0, CHAN_MAX));
    endcase
  endfunction

  // Coordinate within three of c, clamped to the grid.
  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  // Mostly arbitrary segments, with short ones, axis-aligned and diagonal
  // ones, zero-length ones and flat-color ones mixed in.
  function automatic segment_t rand_segment();
    segment_t s;
    int       len;
    s.x_a     = COORD_W'($urandom_range(0, COORD_MAX));
    s.y_a     = COORD_W'($urandom_range(0, COORD_MAX));
    s.x_b     = COORD_W'($urandom_range(0, COORD_MAX));
    s.y_b     = COORD_W'($urandom_range(0, COORD_MAX));
    s.red_a   = rand_chan();
    s.green_a = rand_chan();
    s.blue_a  = rand_chan();
    s.alpha_a = rand_chan();
    s.red_b   = rand_chan();
    s.green_b = rand_chan();
    s.blue_b  = rand_chan();
    s.alpha_b = rand_chan();
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        s.x_b = near_coord(s.x_a);
        s.y_b = near_coord(s.y_a);
      end
      3: s.y_b = s.y_a;
      4: s.x_b = s.x_a;
      5: begin
        // Exact diagonal in a random direction.
        len   = $urandom_range(0, COORD_MAX);
        s.x_b = ($urandom_range(0, 1) != 0) ? COORD_W'(len) : COORD_W'(COORD_MAX - len);
        s.y_b = ($urandom_range(0, 1) != 0) ? COORD_W'(len) : COORD_W'(COORD_MAX - len);
        s.x_a = COORD_W'(COORD_MAX) - s.x_b;
        s.y_a = COORD_W'(COORD_MAX) - s.y_b;
      end
      6: begin
        s.x_b = s.x_a;
        s.y_b = s.y_a;
      end
      7, 8: begin
        s.red_b   = s.red_a;
        s.green_b = s.green_a;
        s.blue_b  = s.blue_a;
        s.alpha_b = s.alpha_a;
      end
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of every field, six of the eight octants, zero length, ties, flat color.
  task automatic test_directed();
    offer_segment(make_segment(0, 0, 0, 0, 32'h00000000, 32'hffffffff));
    offer_segment(make_segment(63, 63, 63, 63, 32'hffffffff, 32'h00000000));
    offer_segment(make_segment(0, 0, 63, 0, 32'h00000000, 32'hffffffff));
    offer_segment(make_segment(63, 63, 0, 63, 32'hff00ff00, 32'h00ff00ff));
    offer_segment(make_segment(5, 0, 5, 63, 32'h0080ff01, 32'hff7f00fe));
    offer_segment(make_segment(40, 63, 40, 0, 32'h12345678, 32'h9abcdef0));
    // Equal |dx| and |dy| goes down the y axis.
    offer_segment(make_segment(0, 0, 63, 63, 32'hffffffff, 32'h00000000));
    offer_segment(make_segment(63, 0, 0, 63, 32'h00000000, 32'hffffffff));
    offer_segment(make_segment(2, 10, 50, 30, 32'h10203040, 32'hf0e0d0c0));
    offer_segment(make_segment(2, 40, 61, 3, 32'hc0d0e0f0, 32'h01020304));
    offer_segment(make_segment(10, 2, 30, 60, 32'h7f7f7f7f, 32'h80808080));
    offer_segment(make_segment(50, 60, 13, 1, 32'h00ff00ff, 32'hff00ff00));
    offer_segment(make_segment(1, 1, 20, 9, 32'h5a3c96e1, 32'h5a3c96e1));
    offer_segment(make_segment(0, 0, 1, 0, 32'h000000ff, 32'hffffff00));
    offer_segment(make_segment(0, 0, 1, 1, 32'hff000000, 32'h00ffffff));
    offer_segment(make_segment(7, 7, 12, 60, 32'h00ff8001, 32'hff0080fe));
    offer_segment(make_segment(60, 0, 0, 17, 32'h3355aacc, 32'hccaa5533));
    offer_segment(make_segment(3, 3, 2, 5, 32'hffffffff, 32'h00000000));
  endtask

  // Hold the receiver off long enough that the core stalls its input while
  // further segments wait.
  task automatic test_input_stall();
    int i;
    hold_start = 1'b1;
    for (i = 0; i < 4; i++)
      offer_segment(make_segment(0, $urandom_range(0, COORD_MAX), COORD_MAX,
                                 $urandom_range(0, COORD_MAX), $urandom, $urandom));
  endtask

  // Let the core run completely dry between segments.
  task automatic test_idle_restart();
    int i;
    for (i = 0; i < 3; i++) begin
      offer_segment(rand_segment());
      drain_pixels();
    end
  endtask

  task automatic test_random(input int count);
    int i;
    for (i = 0; i < count; i++) offer_segment(rand_segment());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    idle_on = 1'b1;
    test_directed();
    test_input_stall();
    test_idle_restart();
    test_random(330);
    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random(60);

    drain_pixels();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/glr_pkg.sv
design/glr_divider.sv
design/gradient_line_rasterizer_core.sv
sim/gradient_line_rasterizer_core_tb.sv
